### rtl/core/multi_convex_polygon_hit_test_defines.svh
// Assertion macros for the convex polygon hit test block.
// Included by the RTL files that carry concurrent assertions; expects clk and rst_n in scope.
`ifndef MULTI_CONVEX_POLYGON_HIT_TEST_DEFINES_SVH
`define MULTI_CONVEX_POLYGON_HIT_TEST_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MCPHT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MCPHT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/mcpht_pkg.sv
// Shared constants and types for the convex polygon hit test block.
// No dependencies; used by the interfaces, the cross product unit and the top level.
`timescale 1ns / 1ps
`default_nettype none

package mcpht_pkg;

  localparam int NUM_POLYGONS_DEF = 8;
  localparam int MAX_VERTICES_DEF = 16;
  localparam int COORD_WIDTH_DEF  = 16;
  localparam int MIN_VERTICES     = 3;

  localparam int CMD_W   = 2;
  localparam int SEL_W   = 3;
  localparam int PNUM_W  = 3;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  // Tag that travels with each vertex read through the cross product unit.
  typedef struct packed {
    logic              valid;
    logic              vtx_first;   // first vertex of a polygon, starts no edge
    logic              edge_first;  // this vertex closes edge 0
    logic              edge_last;   // this vertex closes the last edge
    logic [PNUM_W-1:0] poly;
  } edge_tag_t;

  // Per-polygon outcome from the cross product unit.
  typedef struct packed {
    logic              valid;
    logic              covered;
    logic [PNUM_W-1:0] poly;
  } verdict_t;

endpackage

`default_nettype wire

### rtl/core/mcpht_if.sv
// Valid/ready channel interfaces for the input items and the result items.
// Depends on mcpht_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface mcpht_in_if #(
  parameter int COORD_WIDTH = mcpht_pkg::COORD_WIDTH_DEF
);
  logic                                 valid;
  logic                                 ready;
  logic [mcpht_pkg::CMD_W-1:0]          cmd;
  logic [mcpht_pkg::SEL_W-1:0]          polygon_select;
  logic signed [COORD_WIDTH-1:0]        point_x;
  logic signed [COORD_WIDTH-1:0]        point_y;

  modport source (output valid, cmd, polygon_select, point_x, point_y, input ready);
  modport sink   (input valid, cmd, polygon_select, point_x, point_y, output ready);
endinterface

interface mcpht_out_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [mcpht_pkg::PNUM_W-1:0]  polygon_number;
  logic                          append_rejected;

  modport source (output valid, found, polygon_number, append_rejected, input ready);
  modport sink   (input valid, found, polygon_number, append_rejected, output ready);
endinterface

`default_nettype wire

### rtl/core/mcpht_vtx_mem.sv
// Vertex store: one write port, one registered read port.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module mcpht_vtx_mem #(
  parameter int DEPTH = 128,
  parameter int AW    = 7,
  parameter int DW    = 32
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/core/mcpht_cross_unit.sv
// Shared cross product unit: edge and offset vectors, two products, side compare,
// and the per-polygon agreement check. Depends on mcpht_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mcpht_cross_unit #(
  parameter int COORD_WIDTH = mcpht_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            flush,
  input  wire mcpht_pkg::edge_tag_t            tag_in,
  input  wire logic [2*COORD_WIDTH-1:0]        vtx_data,
  input  wire logic signed [COORD_WIDTH-1:0]   px,
  input  wire logic signed [COORD_WIDTH-1:0]   py,
  output mcpht_pkg::verdict_t                  verdict,
  output logic                                 busy
);
  import mcpht_pkg::*;

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;

  edge_tag_t tag0_r, tag_a_r, tag_b_r;
  edge_tag_t tag_a_nxt;
  verdict_t  verdict_r;

  logic signed [COORD_WIDTH-1:0] cur_x, cur_y;
  logic signed [COORD_WIDTH-1:0] prev_x_r, prev_y_r;
  logic signed [DW-1:0]          ex_r, ey_r, sx_r, sy_r;
  logic signed [PW-1:0]          p1_r, p2_r;
  logic                          side, ref_r, agree_r;

  assign cur_x = vtx_data[2*COORD_WIDTH-1:COORD_WIDTH];
  assign cur_y = vtx_data[COORD_WIDTH-1:0];
  assign side  = p1_r > p2_r;

  // The first vertex of a polygon only loads the previous-vertex registers.
  always_comb begin
    tag_a_nxt       = tag0_r;
    tag_a_nxt.valid = tag0_r.valid && !tag0_r.vtx_first;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || flush) begin
      tag0_r.valid    <= 1'b0;
      tag_a_r.valid   <= 1'b0;
      tag_b_r.valid   <= 1'b0;
      verdict_r.valid <= 1'b0;
    end else begin
      tag0_r          <= tag_in;
      tag_a_r         <= tag_a_nxt;
      tag_b_r         <= tag_a_r;
      verdict_r.valid <= tag_b_r.valid && tag_b_r.edge_last;
      verdict_r.poly  <= tag_b_r.poly;
      verdict_r.covered <= agree_r && (side == ref_r);
    end
  end

  // Edge i runs from the previous vertex to the one just read.
  always_ff @(posedge clk) begin
    if (tag0_r.valid) begin
      prev_x_r <= cur_x;
      prev_y_r <= cur_y;
    end
    ex_r <= DW'(cur_x) - DW'(prev_x_r);
    ey_r <= DW'(cur_y) - DW'(prev_y_r);
    sx_r <= DW'(px) - DW'(prev_x_r);
    sy_r <= DW'(py) - DW'(prev_y_r);
    p1_r <= ex_r * sy_r;
    p2_r <= ey_r * sx_r;
    if (tag_b_r.valid) begin
      if (tag_b_r.edge_first) begin
        ref_r   <= side;
        agree_r <= 1'b1;
      end else begin
        agree_r <= agree_r && (side == ref_r);
      end
    end
  end

  assign verdict = verdict_r;
  assign busy    = tag0_r.valid || tag_a_r.valid || tag_b_r.valid || verdict_r.valid;

endmodule

`default_nettype wire

### rtl/core/multi_convex_polygon_hit_test.sv
// Top level of the convex polygon hit test: sequencer, vertex counts, output register.
// Depends on mcpht_pkg, mcpht_if, mcpht_vtx_mem, mcpht_cross_unit and the defines header.
//
//   channel  direction  handshake        payload
//   in_ch    sink       valid / ready    cmd, polygon_select, point_x, point_y
//   out_ch   source     valid / ready    found, polygon_number, append_rejected
//
// Clear and append: the result is in the output register in the cycle after acceptance.
// A query reads n+1 vertices per polygon of three or more vertices, one per cycle from the
// single vertex memory port, and skips each smaller polygon; the pipeline then drains
// and the result is loaded into the output register.
// The walk stops at the first polygon that contains the point.
// Reset clears the vertex counts at once; the vertex store is not cleared.
// A finished result waits in the output register; no new item is taken until it can move.
`timescale 1ns / 1ps
`default_nettype none

module multi_convex_polygon_hit_test #(
  parameter int NUM_POLYGONS = mcpht_pkg::NUM_POLYGONS_DEF,
  parameter int MAX_VERTICES = mcpht_pkg::MAX_VERTICES_DEF,
  parameter int COORD_WIDTH  = mcpht_pkg::COORD_WIDTH_DEF
) (
  input wire logic    clk,
  input wire logic    rst_n,
  mcpht_in_if.sink    in_ch,
  mcpht_out_if.source out_ch
);
  import mcpht_pkg::*;

  `include "multi_convex_polygon_hit_test_defines.svh"

  localparam int PW    = (NUM_POLYGONS > 1) ? $clog2(NUM_POLYGONS) : 1;
  localparam int PCW   = $clog2(NUM_POLYGONS + 1);
  localparam int VW    = $clog2(MAX_VERTICES);
  localparam int NW    = $clog2(MAX_VERTICES + 1);
  localparam int SW    = (PW > SEL_W) ? PW : SEL_W;
  localparam int AW    = PW + VW;
  localparam int DEPTH = NUM_POLYGONS * (2 ** VW);

  typedef enum logic {S_IDLE, S_QUERY} state_t;

  state_t                        state_r, state_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_found_r, out_found_nxt;
  logic [PNUM_W-1:0]             out_poly_r, out_poly_nxt;
  logic                          out_rej_r, out_rej_nxt;
  logic [PCW-1:0]                poly_r, poly_nxt;
  logic [NW-1:0]                 k_r, k_nxt;
  logic                          hit_r, hit_nxt;
  logic [PNUM_W-1:0]             hit_poly_r, hit_poly_nxt;
  logic signed [COORD_WIDTH-1:0] px_r, py_r;

  logic [NW-1:0]  cnt_r [NUM_POLYGONS];

  logic [SW-1:0]  sel_ext;
  logic [PW-1:0]  sel_idx, cnt_addr;
  logic           sel_ok, out_free, in_ready, accept, query_acc;
  logic [NW-1:0]  cnt_rd;
  logic           app_full, do_clear, do_append;
  logic           issue_done, poly_ok, last_vtx, finish, flush;
  logic [VW-1:0]  rd_idx;
  edge_tag_t      issue_tag;
  verdict_t       verdict;
  logic           busy;
  logic [2*COORD_WIDTH-1:0] rd_data;

  assign sel_ext  = SW'(in_ch.polygon_select);
  assign sel_ok   = {1'b0, sel_ext} < (SW + 1)'(NUM_POLYGONS);
  assign sel_idx  = sel_ext[PW-1:0];
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign accept   = in_ch.valid && in_ready;
  assign query_acc = accept && (in_ch.cmd == CMD_QUERY);

  // One read of the count table: the selected polygon when idle, the walked one in a query.
  assign cnt_addr = (state_r == S_IDLE) ? sel_idx : poly_r[PW-1:0];
  assign cnt_rd   = cnt_r[cnt_addr];
  assign app_full = cnt_rd >= NW'(MAX_VERTICES);

  assign do_clear  = accept && (in_ch.cmd == CMD_CLEAR) && sel_ok;
  assign do_append = accept && (in_ch.cmd == CMD_APPEND) && sel_ok && !app_full;

  assign issue_done = poly_r == PCW'(NUM_POLYGONS);
  assign poly_ok    = cnt_rd >= NW'(MIN_VERTICES);
  assign last_vtx   = k_r == cnt_rd;
  // The closing edge reads vertex 0 again.
  assign rd_idx     = last_vtx ? '0 : k_r[VW-1:0];

  always_comb begin
    issue_tag            = '0;
    issue_tag.vtx_first  = k_r == '0;
    issue_tag.edge_first = k_r == NW'(1);
    issue_tag.edge_last  = last_vtx;
    issue_tag.poly       = PNUM_W'(poly_r);
    issue_tag.valid      = (state_r == S_QUERY) && !hit_r && !issue_done && poly_ok;
  end

  assign finish = (state_r == S_QUERY) && (hit_r || (issue_done && !busy));
  assign flush  = finish && out_free;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_found_nxt = out_found_r;
    out_poly_nxt  = out_poly_r;
    out_rej_nxt   = out_rej_r;
    poly_nxt      = poly_r;
    k_nxt         = k_r;
    hit_nxt       = hit_r;
    hit_poly_nxt  = hit_poly_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_ch.cmd == CMD_QUERY) begin
            state_nxt = S_QUERY;
            poly_nxt  = '0;
            k_nxt     = '0;
            hit_nxt   = 1'b0;
          end else begin
            out_valid_nxt = 1'b1;
            out_found_nxt = 1'b0;
            out_poly_nxt  = '0;
            out_rej_nxt   = (in_ch.cmd == CMD_APPEND) && sel_ok && app_full;
          end
        end
      end
      S_QUERY: begin
        if (!hit_r && !issue_done) begin
          if (!poly_ok || last_vtx) begin
            poly_nxt = poly_r + PCW'(1);
            k_nxt    = '0;
          end else begin
            k_nxt = k_r + NW'(1);
          end
        end
        // Verdicts arrive in polygon order, so the first hit is the lowest index.
        if (verdict.valid && verdict.covered && !hit_r) begin
          hit_nxt      = 1'b1;
          hit_poly_nxt = verdict.poly;
        end
        if (flush) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_found_nxt = hit_r;
          out_poly_nxt  = hit_r ? hit_poly_r : '0;
          out_rej_nxt   = 1'b0;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      hit_r       <= 1'b0;
      poly_r      <= '0;
      k_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      hit_r       <= hit_nxt;
      poly_r      <= poly_nxt;
      k_r         <= k_nxt;
    end
    out_found_r <= out_found_nxt;
    out_poly_r  <= out_poly_nxt;
    out_rej_r   <= out_rej_nxt;
    hit_poly_r  <= hit_poly_nxt;
    if (accept && (in_ch.cmd == CMD_QUERY)) begin
      px_r <= in_ch.point_x;
      py_r <= in_ch.point_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_POLYGONS; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (do_clear) begin
      cnt_r[sel_idx] <= '0;
    end else if (do_append) begin
      cnt_r[sel_idx] <= cnt_rd + NW'(1);
    end
  end

  mcpht_vtx_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (2 * COORD_WIDTH)
  ) u_vtx_mem (
    .clk   (clk),
    .we    (do_append),
    .waddr ({sel_idx, cnt_rd[VW-1:0]}),
    .wdata ({in_ch.point_x, in_ch.point_y}),
    .raddr ({poly_r[PW-1:0], rd_idx}),
    .rdata (rd_data)
  );

  mcpht_cross_unit #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_cross_unit (
    .clk      (clk),
    .rst_n    (rst_n),
    .flush    (flush),
    .tag_in   (issue_tag),
    .vtx_data (rd_data),
    .px       (px_r),
    .py       (py_r),
    .verdict  (verdict),
    .busy     (busy)
  );

  assign in_ch.ready            = in_ready;
  assign out_ch.valid           = out_valid_r;
  assign out_ch.found           = out_found_r;
  assign out_ch.polygon_number  = out_poly_r;
  assign out_ch.append_rejected = out_rej_r;

  `MCPHT_ASSERT_IMP(a_idle_unit_empty, in_ready, !busy, "cross unit busy while taking an item")
  `MCPHT_ASSERT_NXT(a_query_starts, query_acc, state_r == S_QUERY, "query did not start")
  `MCPHT_ASSERT_IMP(a_stop_after_hit, hit_r, !issue_tag.valid, "vertex read issued after a hit")
  `MCPHT_ASSERT_IMP(a_read_in_count, issue_tag.valid, NW'(rd_idx) < cnt_rd, "read beyond count")
  `MCPHT_ASSERT_IMP(a_result_exclusive, out_valid_r, !(out_found_r && out_rej_r), "both flags")

endmodule

`default_nettype wire
